>>> rtl/tbgd_pkg.sv
package tbgd_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int ANG_W        = 20;
    localparam int XY_W         = 19;
    localparam logic signed [ANG_W-1:0] Q16_PI      = 20'sd205887;
    localparam logic signed [ANG_W-1:0] Q16_HALF_PI = 20'sd102944;
    localparam logic signed [XY_W-1:0]  CORDIC_GAIN = 19'sd39797;
    localparam logic signed [23:0]      DEG_PER_RAD = 24'sd3754936;
    localparam int CX_MAX = 8388607;
    localparam int CX_MIN = -8388608;

    typedef struct packed {
        logic [6:0]  cell_column;
        logic [6:0]  cell_row;
        logic [15:0] score;
        logic [15:0] dist_top;
        logic [15:0] dist_right;
        logic [15:0] dist_bottom;
        logic [15:0] dist_left;
        logic signed [15:0] rotation_angle;
    } cell_t;

    typedef struct packed {
        logic signed [23:0] center_x;
        logic signed [23:0] center_y;
        logic [16:0] box_width;
        logic [16:0] box_height;
        logic signed [15:0] angle_degrees;
        logic [15:0] confidence;
    } box_t;

    function automatic logic signed [ANG_W-1:0] atan_q16(input int i);
        case (i)
            0: atan_q16 = 20'sd51472;
            1: atan_q16 = 20'sd30386;
            2: atan_q16 = 20'sd16055;
            3: atan_q16 = 20'sd8150;
            4: atan_q16 = 20'sd4091;
            5: atan_q16 = 20'sd2047;
            6: atan_q16 = 20'sd1024;
            7: atan_q16 = 20'sd512;
            8: atan_q16 = 20'sd256;
            9: atan_q16 = 20'sd128;
            10: atan_q16 = 20'sd64;
            11: atan_q16 = 20'sd32;
            12: atan_q16 = 20'sd16;
            13: atan_q16 = 20'sd8;
            14: atan_q16 = 20'sd4;
            default: atan_q16 = 20'sd2;
        endcase
    endfunction

endpackage

>>> rtl/tbgd_front.sv
module tbgd_front #(
    parameter int MAP_WIDTH  = 128,
    parameter int MAP_HEIGHT = 128
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  tbgd_pkg::cell_t in_cell,
    input  logic [15:0]     threshold,
    output logic            q_valid,
    input  logic            q_ready,
    output tbgd_pkg::cell_t q_cell
);

    localparam int DEPTH = 4;

    tbgd_pkg::cell_t mem_reg [DEPTH];
    logic [1:0] wr_ptr_reg, rd_ptr_reg;
    logic [2:0] count_reg;
    logic       keep;
    logic       push, pop;

    // drop cells below threshold or off the map
    assign keep = (in_cell.score >= threshold)
                  && ({25'd0, in_cell.cell_column} < 32'(MAP_WIDTH))
                  && ({25'd0, in_cell.cell_row} < 32'(MAP_HEIGHT));

    assign in_ready = (count_reg != 3'(DEPTH));
    assign push     = in_valid && in_ready && keep;
    assign q_valid  = (count_reg != 3'd0);
    assign pop      = q_valid && q_ready;
    assign q_cell   = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_cell;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 2'd1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
            count_reg <= count_reg + {2'd0, push} - {2'd0, pop};
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 3'(DEPTH)) else $error("queue count overflow");
    a_full_no_push: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 3'(DEPTH)) |-> !push) else $error("push into full queue");
    a_empty_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 3'd0) |-> !pop) else $error("pop from empty queue");

endmodule

>>> rtl/tbgd_back.sv
module tbgd_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    output logic            q_ready,
    input  tbgd_pkg::cell_t q_cell,
    output logic            out_valid,
    input  logic            out_ready,
    output tbgd_pkg::box_t  out_box
);

    localparam int NS = tbgd_pkg::CORDIC_STEPS;
    localparam int AW = tbgd_pkg::ANG_W;
    localparam int XW = tbgd_pkg::XY_W;
    // stages: 0 fold, 1..NS cordic, NS+1 products, NS+2 sums, NS+3 output
    localparam int NSTG = NS + 4;

    logic advance;
    logic [NSTG-1:0] vld_reg;

    tbgd_pkg::cell_t cell_reg [NSTG-1];
    logic signed [XW-1:0] x_reg [NS+1];
    logic signed [XW-1:0] y_reg [NS+1];
    logic signed [AW-1:0] z_reg [NS+1];
    logic [NS:0] flip_reg;

    logic signed [XW-1:0] c_fin, s_fin;
    logic signed [37:0] pcr_reg, psb_reg, psh_reg, pcw_reg;
    logic signed [37:0] pcb_reg, psr_reg, psw_reg, pch_reg;
    logic signed [39:0] degp_reg;
    logic signed [41:0] accx_reg, accy_reg;
    logic signed [39:0] degr_reg;
    tbgd_pkg::box_t box_reg;

    assign advance   = !vld_reg[NSTG-1] || out_ready;
    assign q_ready   = advance;
    assign out_valid = vld_reg[NSTG-1];
    assign out_box   = box_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (advance)
        begin
            vld_reg <= {vld_reg[NSTG-2:0], q_valid};
        end
    end

    // fold into [-pi/2, pi/2]
    always_ff @(posedge clk)
    begin
        logic signed [AW-1:0] a;
        if (advance)
        begin
            a = AW'(q_cell.rotation_angle) <<< 3;
            cell_reg[0] <= q_cell;
            x_reg[0]    <= tbgd_pkg::CORDIC_GAIN;
            y_reg[0]    <= '0;
            if (a > tbgd_pkg::Q16_HALF_PI)
            begin
                z_reg[0]    <= a - tbgd_pkg::Q16_PI;
                flip_reg[0] <= 1'b1;
            end
            else if (a < -tbgd_pkg::Q16_HALF_PI)
            begin
                z_reg[0]    <= a + tbgd_pkg::Q16_PI;
                flip_reg[0] <= 1'b1;
            end
            else
            begin
                z_reg[0]    <= a;
                flip_reg[0] <= 1'b0;
            end
        end
    end

    for (genvar i = 0; i < NS; i++)
    begin : g_cordic
        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                cell_reg[i+1] <= cell_reg[i];
                flip_reg[i+1] <= flip_reg[i];
                if (z_reg[i] >= 0)
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - tbgd_pkg::atan_q16(i);
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + tbgd_pkg::atan_q16(i);
                end
            end
        end
    end

    assign c_fin = flip_reg[NS] ? -x_reg[NS] : x_reg[NS];
    assign s_fin = flip_reg[NS] ? -y_reg[NS] : y_reg[NS];

    // products
    always_ff @(posedge clk)
    begin
        logic signed [18:0] dt, dr, db, dl, hh, ww;
        tbgd_pkg::cell_t c;
        if (advance)
        begin
            c  = cell_reg[NS];
            dt = {3'd0, c.dist_top};
            dr = {3'd0, c.dist_right};
            db = {3'd0, c.dist_bottom};
            dl = {3'd0, c.dist_left};
            hh = dt + db;
            ww = dr + dl;
            pcr_reg  <= 38'(c_fin * dr);
            psb_reg  <= 38'(s_fin * db);
            psh_reg  <= 38'(s_fin * hh);
            pcw_reg  <= 38'(c_fin * ww);
            pcb_reg  <= 38'(c_fin * db);
            psr_reg  <= 38'(s_fin * dr);
            psw_reg  <= 38'(s_fin * ww);
            pch_reg  <= 38'(c_fin * hh);
            degp_reg <= 40'(-(40'(c.rotation_angle)) * 40'(tbgd_pkg::DEG_PER_RAD));
            cell_reg[NS+1] <= c;
        end
    end

    // sums with rounding offset
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            accx_reg <= 42'(((42'(pcr_reg) + 42'(psb_reg)) <<< 1) - 42'(psh_reg)
                        - 42'(pcw_reg)) + 42'sd65536;
            accy_reg <= 42'(((42'(pcb_reg) - 42'(psr_reg)) <<< 1) + 42'(psw_reg)
                        - 42'(pch_reg)) + 42'sd65536;
            degr_reg <= (degp_reg + 40'sd2097152) >>> 22;
            cell_reg[NS+2] <= cell_reg[NS+1];
        end
    end

    // shift, offset, clamp
    always_ff @(posedge clk)
    begin
        logic signed [33:0] cx, cy;
        tbgd_pkg::cell_t c;
        if (advance)
        begin
            c  = cell_reg[NS+2];
            cx = 34'(accx_reg >>> 17) + 34'({c.cell_column, 8'd0});
            cy = 34'(accy_reg >>> 17) + 34'({c.cell_row, 8'd0});
            box_reg.center_x <= (cx > 34'(tbgd_pkg::CX_MAX)) ? 24'sh7fffff :
                (cx < 34'(tbgd_pkg::CX_MIN)) ? 24'sh800000 : cx[23:0];
            box_reg.center_y <= (cy > 34'(tbgd_pkg::CX_MAX)) ? 24'sh7fffff :
                (cy < 34'(tbgd_pkg::CX_MIN)) ? 24'sh800000 : cy[23:0];
            box_reg.angle_degrees <= (degr_reg > 40'sd32767) ? 16'sh7fff :
                (degr_reg < -40'sd32768) ? 16'sh8000 : degr_reg[15:0];
            box_reg.box_width  <= {1'b0, c.dist_right} + {1'b0, c.dist_left};
            box_reg.box_height <= {1'b0, c.dist_top} + {1'b0, c.dist_bottom};
            box_reg.confidence <= c.score;
        end
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> $stable(vld_reg)) else $error("pipe moved on stall");
    a_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (q_valid && q_ready) |=> vld_reg[0]) else $error("transfer lost");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> q_ready) else $error("stall without output");

endmodule

>>> rtl/text_box_geometry_decode.sv
// Path: an input transfer writes the 4-entry front queue; the cell then
// passes fold, 16 CORDIC stages, product, sum and the round/clamp output
// register in order; the back pipeline holds while its output waits on out_ready.
// Throughput: one cell per cycle unless stalled; drops still handshake.
// Reset: rst_n asynchronous active low clears all valid state and the queue;
// the score threshold register returns to 32768.
module text_box_geometry_decode #(
    parameter int MAP_WIDTH  = 128,
    parameter int MAP_HEIGHT = 128
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [15:0]        cfg_wdata,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [6:0]         cell_column,
    input  logic [6:0]         cell_row,
    input  logic [15:0]        score,
    input  logic [15:0]        dist_top,
    input  logic [15:0]        dist_right,
    input  logic [15:0]        dist_bottom,
    input  logic [15:0]        dist_left,
    input  logic signed [15:0] rotation_angle,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [23:0] center_x,
    output logic signed [23:0] center_y,
    output logic [16:0]        box_width,
    output logic [16:0]        box_height,
    output logic signed [15:0] angle_degrees,
    output logic [15:0]        confidence
);

    logic [15:0] thr_reg;
    tbgd_pkg::cell_t in_cell, q_cell;
    tbgd_pkg::box_t  box;
    logic q_valid, q_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= 16'd32768;
        end
        else if (cfg_we)
        begin
            thr_reg <= cfg_wdata;
        end
    end

    assign in_cell = '{cell_column, cell_row, score, dist_top, dist_right,
                       dist_bottom, dist_left, rotation_angle};

    tbgd_front #(.MAP_WIDTH(MAP_WIDTH), .MAP_HEIGHT(MAP_HEIGHT)) u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .in_cell(in_cell), .threshold(thr_reg), .q_valid(q_valid),
        .q_ready(q_ready), .q_cell(q_cell));

    tbgd_back u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_ready(q_ready),
        .q_cell(q_cell), .out_valid(out_valid), .out_ready(out_ready),
        .out_box(box));

    assign center_x      = box.center_x;
    assign center_y      = box.center_y;
    assign box_width     = box.box_width;
    assign box_height    = box.box_height;
    assign angle_degrees = box.angle_degrees;
    assign confidence    = box.confidence;

endmodule
